// ===== hw/rtl/rmde_pkg.sv =====
// Shared types and constants of the raster morphology dilate/erode block.
`timescale 1ns / 1ps

package rmde_pkg;

  localparam int PIX_W      = 8;
  localparam int ROW_W      = 16;
  localparam int COL_OUT_W  = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_WID_W  = 11;

  localparam logic [CFG_IDX_W-1:0] REG_MODE        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_CHAR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPL_CHAR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMG_WIDTH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IMG_HEIGHT  = 3'd4;

  localparam logic MODE_DILATE = 1'b0;
  localparam logic MODE_ERODE  = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [PIX_W-1:0] target_char;
    logic [PIX_W-1:0] replacement_char;
  } rmde_cfg_t;

  typedef struct packed {
    logic [3:0]              ok;
    logic [3:0][PIX_W-1:0]   px;
  } rmde_nbrs_t;

  typedef struct packed {
    logic has_up;
    logic up2;
    logic c_ge1;
    logic c_ge2;
    logic right_ok;
    logic last_row;
    logic frame_end;
  } rmde_flags_t;

  typedef struct packed {
    logic [PIX_W-1:0]     pixel_out;
    logic [ROW_W-1:0]     out_row;
    logic [COL_OUT_W-1:0] out_col;
    logic                 frame_last;
  } rmde_res_t;

endpackage

// ===== hw/rtl/rmde_if.sv =====
// Valid/ready stream interfaces for the pixel and result channels.
`timescale 1ns / 1ps

interface rmde_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink (input valid, input pixel_in, output ready);
endinterface

interface rmde_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  pixel_out;
  logic [15:0] out_row;
  logic [9:0]  out_col;
  logic        frame_last;

  modport source (output valid, output pixel_out, output out_row, output out_col,
                  output frame_last, input ready);
  modport sink (input valid, input pixel_out, input out_row, input out_col,
                input frame_last, output ready);
endinterface

// ===== hw/rtl/rmde_line_ram.sv =====
// Generic RAM: one write port, two read ports with registered read data.
`timescale 1ns / 1ps

module rmde_line_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr_a,
  input  logic [AW-1:0]    rd_addr_b,
  output logic [WIDTH-1:0] rd_data_a,
  output logic [WIDTH-1:0] rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_a_r;
  logic [WIDTH-1:0] rd_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_r <= mem[rd_addr_a];
      rd_b_r <= mem[rd_addr_b];
    end
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

// ===== hw/rtl/rmde_judge.sv =====
// Four-neighbour dilate/erode decision for one pixel.
`timescale 1ns / 1ps

module rmde_judge (
  input  rmde_pkg::rmde_cfg_t        cfg,
  input  logic [rmde_pkg::PIX_W-1:0] center,
  input  rmde_pkg::rmde_nbrs_t       nbrs,
  output logic [rmde_pkg::PIX_W-1:0] result
);

  logic any_eq;
  logic any_ne;

  always_comb begin
    any_eq = 1'b0;
    any_ne = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (nbrs.ok[i]) begin
        if (nbrs.px[i] == cfg.target_char) begin
          any_eq = 1'b1;
        end else begin
          any_ne = 1'b1;
        end
      end
    end
    result = center;
    case (cfg.mode)
      rmde_pkg::MODE_DILATE: begin
        if (center != cfg.target_char && any_eq) begin
          result = cfg.target_char;
        end
      end
      default: begin
        if (center == cfg.target_char && any_ne) begin
          result = cfg.replacement_char;
        end
      end
    endcase
  end

endmodule

// ===== hw/rtl/raster_morphology_dilate_erode_unit.sv =====
// Top level of the streaming four-neighbour dilate/erode block.
//
// Pixels enter on in_px in raster order, one request per pixel, and results
// leave on out_res with their row, column and a frame_last flag on the
// bottom-right pixel. A pixel's result appears once its lower neighbour has
// arrived; last-row pixels follow one pixel late and the final pixel of the
// frame flushes the rest (three results for that request).
// An accepted pixel and its line store read are registered in the lookup
// stage. One pixel is taken per cycle while the receiver is ready, set by the
// single stage between line store read and result buffer; on the last row
// most pixels yield two results, so there the output channel limits the
// rate. The line store holds two rows of MAX_WIDTH pixels and needs no
// clearing. Reset clears counters, pipeline and characters and sets dilate
// mode and a 2 by 2 image. When the receiver stalls, up to three results wait
// in the result buffer, one more pixel waits in the lookup stage,
// and in_px.ready then drops. Registers are written through
// cfg_we/cfg_index/cfg_wdata only while idle; the block does not enforce it.
`timescale 1ns / 1ps

module raster_morphology_dilate_erode_unit #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [rmde_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rmde_pkg::CFG_DATA_W-1:0] cfg_wdata,
  rmde_pix_if.sink                        in_px,
  rmde_res_if.source                      out_res
);

  localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WCW = CW + 1;
  localparam int PW  = rmde_pkg::PIX_W;
  localparam int RW  = rmde_pkg::ROW_W;

  // configuration
  logic                         cfg_mode_r;
  logic [PW-1:0]                cfg_target_r;
  logic [PW-1:0]                cfg_repl_r;
  logic [rmde_pkg::CFG_WID_W-1:0] cfg_width_r;
  logic [RW-1:0]                cfg_height_r;
  rmde_pkg::rmde_cfg_t          jcfg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_mode_r   <= rmde_pkg::MODE_DILATE;
      cfg_target_r <= '0;
      cfg_repl_r   <= '0;
      cfg_width_r  <= rmde_pkg::CFG_WID_W'(2);
      cfg_height_r <= RW'(2);
    end else if (cfg_we) begin
      unique case (cfg_index)
        rmde_pkg::REG_MODE:        cfg_mode_r   <= cfg_wdata[0];
        rmde_pkg::REG_TARGET_CHAR: cfg_target_r <= cfg_wdata[PW-1:0];
        rmde_pkg::REG_REPL_CHAR:   cfg_repl_r   <= cfg_wdata[PW-1:0];
        rmde_pkg::REG_IMG_WIDTH:   cfg_width_r  <= cfg_wdata[rmde_pkg::CFG_WID_W-1:0];
        rmde_pkg::REG_IMG_HEIGHT:  cfg_height_r <= cfg_wdata[RW-1:0];
        default: ;
      endcase
    end
  end

  assign jcfg.mode             = cfg_mode_r;
  assign jcfg.target_char      = cfg_target_r;
  assign jcfg.replacement_char = cfg_repl_r;

  // geometry in use
  logic [WCW-1:0] w_eff;
  logic [RW-1:0]  h_eff;

  always_comb begin
    if (cfg_width_r < rmde_pkg::CFG_WID_W'(2)) begin
      w_eff = WCW'(2);
    end else if (32'(cfg_width_r) > MAX_WIDTH) begin
      w_eff = WCW'(MAX_WIDTH);
    end else begin
      w_eff = WCW'(cfg_width_r);
    end
    h_eff = (cfg_height_r < RW'(2)) ? RW'(2) : cfg_height_r;
  end

  // raster position of the arriving pixel
  logic [CW-1:0]  col_count_r, col_count_nxt;
  logic [RW-1:0]  row_count_r, row_count_nxt;
  logic [PW-1:0]  left_lo_r, left_hi_r;
  logic [CW-1:0]  c_new;
  logic [RW-1:0]  r_new;
  logic [RW:0]    r_tmp;
  logic [RW:0]    r_inc;
  logic [WCW-1:0] c_inc;
  rmde_pkg::rmde_flags_t flags_new;

  always_comb begin
    if (WCW'(col_count_r) >= w_eff) begin
      c_new = '0;
      r_tmp = (RW+1)'(row_count_r) + (RW+1)'(1);
    end else begin
      c_new = col_count_r;
      r_tmp = (RW+1)'(row_count_r);
    end
    r_new = (r_tmp >= (RW+1)'(h_eff)) ? '0 : r_tmp[RW-1:0];
    c_inc = WCW'(c_new) + WCW'(1);
    r_inc = (RW+1)'(r_new) + (RW+1)'(1);
    if (c_inc >= w_eff) begin
      col_count_nxt = '0;
      row_count_nxt = (r_inc >= (RW+1)'(h_eff)) ? '0 : r_inc[RW-1:0];
    end else begin
      col_count_nxt = c_inc[CW-1:0];
      row_count_nxt = r_new;
    end
    flags_new.has_up    = (r_new != '0);
    flags_new.up2       = (r_new >= RW'(2));
    flags_new.c_ge1     = (c_new != '0);
    flags_new.c_ge2     = (WCW'(c_new) >= WCW'(2));
    flags_new.right_ok  = (c_inc < w_eff);
    flags_new.last_row  = (r_inc == (RW+1)'(h_eff));
    flags_new.frame_end = flags_new.last_row && (c_inc == w_eff);
  end

  // lookup stage
  logic                  accept;
  logic                  s1_fire;
  logic                  s1_valid_r;
  logic [PW-1:0]         s1_p_r;
  logic [CW-1:0]         s1_c_r;
  logic [RW-1:0]         s1_r_r;
  logic [PW-1:0]         s1_lo_r, s1_hi_r;
  rmde_pkg::rmde_flags_t s1_flags_r;
  logic                  byp_a_r, byp_b_r;
  logic [2*PW-1:0]       byp_data_r;
  logic [PW-1:0]         prev_center_r;
  logic [CW-1:0]         rd_addr_b;
  logic [2*PW-1:0]       rd_data_a, rd_data_b;
  logic [2*PW-1:0]       wr_data;
  logic [PW-1:0]         center_eff, up_eff, right_eff;

  assign accept       = in_px.valid && in_px.ready;
  assign in_px.ready  = !s1_valid_r || s1_fire;
  assign rd_addr_b    = flags_new.right_ok ? c_inc[CW-1:0] : c_new;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r <= '0;
      row_count_r <= '0;
      left_lo_r   <= '0;
      left_hi_r   <= '0;
      s1_valid_r  <= 1'b0;
    end else begin
      if (accept) begin
        col_count_r <= col_count_nxt;
        row_count_r <= row_count_nxt;
        left_lo_r   <= in_px.pixel_in;
        left_hi_r   <= left_lo_r;
        s1_valid_r  <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_p_r     <= in_px.pixel_in;
      s1_c_r     <= c_new;
      s1_r_r     <= r_new;
      s1_lo_r    <= left_lo_r;
      s1_hi_r    <= left_hi_r;
      s1_flags_r <= flags_new;
      byp_a_r    <= s1_fire && (s1_c_r == c_new);
      byp_b_r    <= s1_fire && (s1_c_r == rd_addr_b);
      byp_data_r <= wr_data;
    end
    if (s1_fire) begin
      prev_center_r <= center_eff;
    end
  end

  assign center_eff = byp_a_r ? byp_data_r[PW-1:0]      : rd_data_a[PW-1:0];
  assign up_eff     = byp_a_r ? byp_data_r[2*PW-1:PW]   : rd_data_a[2*PW-1:PW];
  assign right_eff  = byp_b_r ? byp_data_r[PW-1:0]      : rd_data_b[PW-1:0];
  assign wr_data    = {center_eff, s1_p_r};

  rmde_line_ram #(
    .WIDTH (2 * PW),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk       (clk),
    .wr_en     (s1_fire),
    .wr_addr   (s1_c_r),
    .wr_data   (wr_data),
    .rd_en     (accept),
    .rd_addr_a (c_new),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  // neighbourhoods of the up to three finished pixels
  rmde_pkg::rmde_nbrs_t nb_mid, nb_left, nb_self;
  logic [PW-1:0]        px_mid, px_left, px_self;

  assign nb_mid.ok  = {s1_flags_r.right_ok, s1_flags_r.c_ge1, 1'b1, s1_flags_r.up2};
  assign nb_mid.px  = {right_eff, prev_center_r, s1_p_r, up_eff};
  assign nb_left.ok = {1'b1, s1_flags_r.c_ge2, 1'b0, 1'b1};
  assign nb_left.px = {s1_p_r, s1_hi_r, PW'(0), prev_center_r};
  assign nb_self.ok = {1'b0, 1'b1, 1'b0, 1'b1};
  assign nb_self.px = {PW'(0), s1_lo_r, PW'(0), center_eff};

  rmde_judge u_judge_mid (
    .cfg (jcfg), .center (center_eff), .nbrs (nb_mid), .result (px_mid)
  );

  rmde_judge u_judge_left (
    .cfg (jcfg), .center (s1_lo_r), .nbrs (nb_left), .result (px_left)
  );

  rmde_judge u_judge_self (
    .cfg (jcfg), .center (s1_p_r), .nbrs (nb_self), .result (px_self)
  );

  // result buffer
  rmde_pkg::rmde_res_t res_r [3];
  rmde_pkg::rmde_res_t res_new [3];
  logic [1:0]          rem_r;
  logic [1:0]          n_res;
  logic                buf_free;
  logic                load;
  logic                pop;

  assign n_res = 2'(s1_flags_r.has_up)
               + 2'(s1_flags_r.last_row && s1_flags_r.c_ge1)
               + 2'(s1_flags_r.frame_end);
  assign pop      = out_res.valid && out_res.ready;
  assign buf_free = (rem_r == 2'd0) || (rem_r == 2'd1 && out_res.ready);
  assign s1_fire  = s1_valid_r && ((n_res == 2'd0) || buf_free);
  assign load     = s1_fire && (n_res != 2'd0);

  always_comb begin
    res_new[0].pixel_out  = px_mid;
    res_new[0].out_row    = s1_r_r - RW'(1);
    res_new[0].out_col    = rmde_pkg::COL_OUT_W'(s1_c_r);
    res_new[0].frame_last = 1'b0;
    res_new[1].pixel_out  = px_left;
    res_new[1].out_row    = s1_r_r;
    res_new[1].out_col    = rmde_pkg::COL_OUT_W'(s1_c_r - CW'(1));
    res_new[1].frame_last = 1'b0;
    res_new[2].pixel_out  = px_self;
    res_new[2].out_row    = s1_r_r;
    res_new[2].out_col    = rmde_pkg::COL_OUT_W'(s1_c_r);
    res_new[2].frame_last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 2'd0;
    end else if (load) begin
      rem_r <= n_res;
    end else if (pop) begin
      rem_r <= rem_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_new;
    end else if (pop) begin
      res_r[0] <= res_r[1];
      res_r[1] <= res_r[2];
    end
  end

  assign out_res.valid      = (rem_r != 2'd0);
  assign out_res.pixel_out  = res_r[0].pixel_out;
  assign out_res.out_row    = res_r[0].out_row;
  assign out_res.out_col    = res_r[0].out_col;
  assign out_res.frame_last = res_r[0].frame_last;

  // checks
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_fire) |=> (s1_valid_r && $stable(s1_c_r) && $stable(s1_p_r)))
    else $error("lookup stage lost a stalled pixel");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && s1_valid_r) |-> s1_fire)
    else $error("pixel accepted over an occupied lookup stage");

  a_frame_end_three: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_flags_r.frame_end) |-> (n_res == 2'd3))
    else $error("final pixel did not flush three results");

  a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && rem_r == 2'd1 && !load) |=> !out_res.valid)
    else $error("result buffer did not empty after last result");

endmodule

// ===== dv/tb_raster_morphology_dilate_erode_unit.sv =====
// Testbench for the dilate/erode block: streams raster frames and checks each result pixel.
`timescale 1ns / 1ps

module tb_raster_morphology_dilate_erode_unit;

  localparam int MAX_W       = 1024;
  localparam int CYCLE_LIMIT = 400000;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            cfg_we;
  logic [rmde_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [rmde_pkg::CFG_DATA_W-1:0] cfg_wdata;

  rmde_pix_if px_if ();
  rmde_res_if res_if ();

  raster_morphology_dilate_erode_unit #(.MAX_WIDTH(MAX_W)) dut (
    .clk,
    .rst_n,
    .cfg_we,
    .cfg_index,
    .cfg_wdata,
    .in_px(px_if),
    .out_res(res_if)
  );

  logic                           mode_sel    = rmde_pkg::MODE_DILATE;
  logic [rmde_pkg::PIX_W-1:0]     char_target = '0;
  logic [rmde_pkg::PIX_W-1:0]     char_repl   = '0;
  logic [rmde_pkg::CFG_WID_W-1:0] width_reg   = 11'd2;
  logic [rmde_pkg::ROW_W-1:0]     height_reg  = 16'd2;

  logic [rmde_pkg::PIX_W-1:0] row_above     [MAX_W];
  logic [rmde_pkg::PIX_W-1:0] row_two_above [MAX_W];
  logic [15:0]                left_pair = '0;
  int unsigned                col_pos   = 0;
  int unsigned                row_pos   = 0;

  logic [rmde_pkg::PIX_W-1:0] raster_feed [$];
  rmde_pkg::rmde_res_t        judged_pixels [$];
  rmde_pkg::rmde_res_t        head;
  int unsigned                pixels_queued = 0;
  int unsigned                pixels_taken  = 0;
  int unsigned                fail_count    = 0;
  int unsigned                gap_pct       = 0;
  int unsigned                stall_pct     = 0;
  int unsigned                watch_cycles;
  bit                         px_fired = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [rmde_pkg::PIX_W-1:0] judge_pixel(
      input logic [rmde_pkg::PIX_W-1:0]      center,
      input logic [3:0][rmde_pkg::PIX_W-1:0] nb,
      input logic [3:0]                      ok);
    logic any_eq;
    logic any_ne;
    int   i;
    any_eq = 1'b0;
    any_ne = 1'b0;
    for (i = 0; i < 4; i++) begin
      if (ok[i]) begin
        if (nb[i] == char_target) any_eq = 1'b1;
        else any_ne = 1'b1;
      end
    end
    if (mode_sel == rmde_pkg::MODE_DILATE) begin
      return (center != char_target && any_eq) ? char_target : center;
    end
    return (center == char_target && any_ne) ? char_repl : center;
  endfunction

  function automatic rmde_pkg::rmde_res_t make_res(input logic [rmde_pkg::PIX_W-1:0] px,
                                                   input int unsigned row,
                                                   input int unsigned col,
                                                   input logic last);
    rmde_pkg::rmde_res_t res;
    res.pixel_out  = px;
    res.out_row    = rmde_pkg::ROW_W'(row);
    res.out_col    = rmde_pkg::COL_OUT_W'(col);
    res.frame_last = last;
    return res;
  endfunction

  task automatic queue_result(input rmde_pkg::rmde_res_t res);
    judged_pixels = {judged_pixels, res};
  endtask

  task automatic apply_morphology(input logic [rmde_pkg::PIX_W-1:0] p);
    int unsigned                     w;
    int unsigned                     h;
    int unsigned                     r;
    int unsigned                     c;
    logic [rmde_pkg::PIX_W-1:0]      lo;
    logic [rmde_pkg::PIX_W-1:0]      hi;
    logic [3:0][rmde_pkg::PIX_W-1:0] nb;
    logic [3:0]                      ok;
    w = width_reg;
    if (w < 2) w = 2;
    if (w > MAX_W) w = MAX_W;
    h = height_reg;
    if (h < 2) h = 2;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    r  = row_pos;
    c  = col_pos;
    lo = left_pair[7:0];
    hi = left_pair[15:8];

    // pixel above the arriving one now has all its neighbours
    if (r >= 1) begin
      nb[0] = (r >= 2) ? row_two_above[c] : '0;
      ok[0] = (r >= 2);
      nb[1] = p;
      ok[1] = 1'b1;
      nb[2] = (c >= 1) ? row_two_above[c - 1] : '0;
      ok[2] = (c >= 1);
      nb[3] = (c + 1 < w) ? row_above[c + 1] : '0;
      ok[3] = (c + 1 < w);
      queue_result(make_res(judge_pixel(row_above[c], nb, ok), r - 1, c, 1'b0));
    end
    if (r == h - 1 && c >= 1) begin
      nb[0] = row_two_above[c - 1];
      ok[0] = 1'b1;
      nb[1] = '0;
      ok[1] = 1'b0;
      nb[2] = hi;
      ok[2] = (c >= 2);
      nb[3] = p;
      ok[3] = 1'b1;
      queue_result(make_res(judge_pixel(lo, nb, ok), r, c - 1, 1'b0));
    end
    if (r == h - 1 && c == w - 1) begin
      nb[0] = row_above[c];
      ok[0] = 1'b1;
      nb[1] = '0;
      ok[1] = 1'b0;
      nb[2] = lo;
      ok[2] = 1'b1;
      nb[3] = '0;
      ok[3] = 1'b0;
      queue_result(make_res(judge_pixel(p, nb, ok), r, c, 1'b1));
    end

    row_two_above[c] = row_above[c];
    row_above[c]     = p;
    left_pair        = {lo, p};
    col_pos          = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  always @(posedge clk) begin
    px_fired = rst_n && px_if.valid && px_if.ready;
    if (px_fired) begin
      apply_morphology(px_if.pixel_in);
      pixels_taken++;
    end
    if (rst_n && res_if.valid && res_if.ready) begin
      if (judged_pixels.size() == 0) begin
        $display("%0t: unexpected result px=%02h row=%0d col=%0d last=%0b", $time,
                 res_if.pixel_out, res_if.out_row, res_if.out_col, res_if.frame_last);
        fail_count++;
      end else begin
        head = judged_pixels.pop_front();
        if (res_if.pixel_out !== head.pixel_out || res_if.out_row !== head.out_row ||
            res_if.out_col !== head.out_col || res_if.frame_last !== head.frame_last) begin
          $display("%0t: mismatch expected px=%02h row=%0d col=%0d last=%0b", $time,
                   head.pixel_out, head.out_row, head.out_col, head.frame_last);
          $display("%0t:          actual   px=%02h row=%0d col=%0d last=%0b", $time,
                   res_if.pixel_out, res_if.out_row, res_if.out_col, res_if.frame_last);
          fail_count++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      px_if.valid  <= 1'b0;
      res_if.ready <= 1'b0;
    end else begin
      // hold the request until it is taken
      if (!px_if.valid || px_fired) begin
        if (raster_feed.size() != 0 && $urandom_range(99) >= gap_pct) begin
          px_if.valid    <= 1'b1;
          px_if.pixel_in <= raster_feed.pop_front();
        end else begin
          px_if.valid <= 1'b0;
        end
      end
      res_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic write_reg(input logic [rmde_pkg::CFG_IDX_W-1:0]  idx,
                           input logic [rmde_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      rmde_pkg::REG_MODE:        mode_sel    = data[0];
      rmde_pkg::REG_TARGET_CHAR: char_target = data[rmde_pkg::PIX_W-1:0];
      rmde_pkg::REG_REPL_CHAR:   char_repl   = data[rmde_pkg::PIX_W-1:0];
      rmde_pkg::REG_IMG_WIDTH:   width_reg   = data[rmde_pkg::CFG_WID_W-1:0];
      rmde_pkg::REG_IMG_HEIGHT:  height_reg  = data[rmde_pkg::ROW_W-1:0];
      default: ;
    endcase
  endtask

  task automatic feed(input logic [rmde_pkg::PIX_W-1:0] p);
    raster_feed = {raster_feed, p};
    pixels_queued++;
  endtask

  task automatic wait_idle();
    while (pixels_taken != pixels_queued || judged_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_idling(input int unsigned phase);
    case (phase % 4)
      0: begin gap_pct = 0;  stall_pct = 0;  end
      1: begin gap_pct = 46; stall_pct = 0;  end
      2: begin gap_pct = 0;  stall_pct = 46; end
      default: begin gap_pct = 10; stall_pct = 10; end
    endcase
  endtask

  function automatic logic [rmde_pkg::PIX_W-1:0] random_pixel();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 5) return char_target;
    if (pick < 7) return char_repl;
    return rmde_pkg::PIX_W'($urandom);
  endfunction

  initial begin
    for (watch_cycles = 0; watch_cycles < CYCLE_LIMIT; watch_cycles++) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  initial begin
    logic [rmde_pkg::PIX_W-1:0] directed [$];
    int unsigned                w_eff;
    int unsigned                h_eff;
    int unsigned                n_px;
    int unsigned                split;
    int unsigned                phase_no;
    int unsigned                random_fed;
    int unsigned                wv;
    int unsigned                hv;
    int unsigned                k;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    px_if.valid    = 1'b0;
    px_if.pixel_in = '0;
    res_if.ready   = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    set_idling(0);
    directed = '{8'h00, 8'hFF, 8'h7F, 8'h80};
    foreach (directed[i]) feed(directed[i]);
    wait_idle();

    write_reg(rmde_pkg::REG_MODE, 16'(rmde_pkg::MODE_ERODE));
    write_reg(rmde_pkg::REG_TARGET_CHAR, 16'h00AA);
    write_reg(rmde_pkg::REG_REPL_CHAR, 16'h0055);
    write_reg(rmde_pkg::REG_IMG_WIDTH, 16'd3);
    write_reg(rmde_pkg::REG_IMG_HEIGHT, 16'd3);
    directed = '{8'hAA, 8'hAA, 8'h01, 8'hAA, 8'hAA, 8'hAA, 8'hFE, 8'hAA, 8'hAA};
    foreach (directed[i]) feed(directed[i]);
    wait_idle();

    // undersized geometry falls back to 2 by 2
    write_reg(rmde_pkg::REG_MODE, 16'(rmde_pkg::MODE_DILATE));
    write_reg(rmde_pkg::REG_TARGET_CHAR, 16'h00FF);
    write_reg(rmde_pkg::REG_IMG_WIDTH, 16'd1);
    write_reg(rmde_pkg::REG_IMG_HEIGHT, 16'd0);
    directed = '{8'h00, 8'hFF, 8'h12, 8'h34};
    foreach (directed[i]) feed(directed[i]);
    wait_idle();

    write_reg(rmde_pkg::REG_MODE, 16'(rmde_pkg::MODE_ERODE));
    write_reg(rmde_pkg::REG_TARGET_CHAR, 16'h0000);
    write_reg(rmde_pkg::REG_REPL_CHAR, 16'h00FF);
    write_reg(rmde_pkg::REG_IMG_WIDTH, 16'd0);
    write_reg(rmde_pkg::REG_IMG_HEIGHT, 16'd1);
    directed = '{8'h00, 8'h00, 8'h00, 8'hC3};
    foreach (directed[i]) feed(directed[i]);
    wait_idle();

    // fill both rows of the line store over the columns used below
    set_idling(3);
    write_reg(rmde_pkg::REG_MODE, 16'(rmde_pkg::MODE_DILATE));
    write_reg(rmde_pkg::REG_TARGET_CHAR, 16'h005A);
    write_reg(rmde_pkg::REG_IMG_WIDTH, 16'd16);
    write_reg(rmde_pkg::REG_IMG_HEIGHT, 16'd2);
    repeat (32) feed(random_pixel());
    wait_idle();

    // oversized width clamps to the line store size
    write_reg(rmde_pkg::REG_IMG_WIDTH, 16'h07FF);
    repeat (16) feed(random_pixel());
    wait_idle();

    // geometry changes in the middle of a frame
    set_idling(0);
    write_reg(rmde_pkg::REG_IMG_WIDTH, 16'(MAX_W));
    write_reg(rmde_pkg::REG_IMG_HEIGHT, 16'd3);
    repeat (10) feed(random_pixel());
    wait_idle();
    write_reg(rmde_pkg::REG_IMG_WIDTH, 16'd4);
    write_reg(rmde_pkg::REG_IMG_HEIGHT, 16'hFFFF);
    repeat (24) feed(random_pixel());
    wait_idle();

    random_fed = 0;
    phase_no   = 0;
    while (random_fed < 270) begin
      set_idling(phase_no);
      phase_no++;
      wv = ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(2, 7);
      hv = ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(2, 5);
      write_reg(rmde_pkg::REG_MODE, 16'($urandom));
      write_reg(rmde_pkg::REG_TARGET_CHAR, 16'($urandom));
      write_reg(rmde_pkg::REG_REPL_CHAR, 16'($urandom));
      write_reg(rmde_pkg::REG_IMG_WIDTH, {5'($urandom), 11'(wv)});
      write_reg(rmde_pkg::REG_IMG_HEIGHT, 16'(hv));
      w_eff = (width_reg < 2) ? 2 : width_reg;
      h_eff = (height_reg < 2) ? 2 : height_reg;
      n_px  = w_eff * h_eff;
      if ($urandom_range(7) == 0) n_px = $urandom_range(1, n_px - 1);
      split = ($urandom_range(5) == 0) ? $urandom_range(1, n_px) : n_px;
      for (k = 0; k < n_px; k++) begin
        if (k == split) wait_idle();
        feed(random_pixel());
      end
      random_fed += n_px;
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
